[hw/rtl/sine_cosine_series_assert.svh]
// assertion macros for the rtl modules, used by scs_queue
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef SINE_COSINE_SERIES_ASSERT_SVH
`define SINE_COSINE_SERIES_ASSERT_SVH

// same-cycle implication
`define SCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scs assertion failed");

// next-cycle implication
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scs assertion failed");

`endif

[hw/rtl/scs_pkg.sv]
// shared types, constants and helper functions for sine_cosine_series
// no dependencies
package scs_pkg;

  localparam logic [31:0] INV_PI_Q33  = 32'd2734261102;
  localparam logic [31:0] INV_180_Q38 = 32'd1527099483;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam int          RAD_SHIFT   = 33;
  localparam int          DEG_SHIFT   = 38;
  localparam int          QDEPTH      = 8;
  localparam int          QPTR_W      = $clog2(QDEPTH);
  localparam int          COEF_COUNT  = 24;

  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [33:0] NEG_ONE_Q30 = -34'sd1073741824;

  localparam logic [30:0] INV_FACT [COEF_COUNT] = '{
    31'd1073741824, 31'd1073741824, 31'd536870912, 31'd178956971, 31'd44739243,
    31'd8947849, 31'd1491308, 31'd213044, 31'd26631, 31'd2959, 31'd296, 31'd27,
    31'd2, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0,
    31'd0
  };

  typedef struct packed {
    logic        op;
    logic        neg;
    logic [30:0] rm;
  } item_t;

  function automatic logic signed [33:0] coef(input logic [4:0] n);
    logic signed [33:0] c;
    c = '0;
    if (32'(n) < COEF_COUNT) begin
      c = signed'({3'b000, INV_FACT[n]});
    end
    return c;
  endfunction

  // a * b / 2^30, rounded half away from zero
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic [31:0] b);
    logic        neg;
    logic [33:0] mag;
    logic [65:0] p;
    neg = a[33];
    mag = neg ? 34'(-a) : 34'(a);
    p   = (({32'b0, mag} * {34'b0, b}) + (66'd1 << 29)) >> 30;
    return neg ? -signed'(p[33:0]) : signed'(p[33:0]);
  endfunction

endpackage

[hw/rtl/sine_cosine_series.sv]
// channel   direction  handshake          payload
// command   in         start / busy       op, in_degrees, angle
// result    out        strobe (1 cycle)   value
//
// one angle accepted per cycle; each passes through four front stages, the
// queue register, TERMS series stages and the result register
// the series pipeline issues one horner step per stage, so the rate is set by
// the front multiplier chain and is one item per clock
// synchronous reset clears all valid bits and the queue; busy never rises
// since the back end drains the queue every cycle and results cannot stall
module sine_cosine_series #(
  parameter int TERMS           = 8,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic                in_degrees,
  input  logic signed [31:0]  angle,
  output logic                strobe,
  output logic signed [31:0]  value
);

  logic                           f_valid, q_pop;
  scs_pkg::item_t                 f_item, q_item;
  logic [2:0]                     inflight;
  logic [scs_pkg::QPTR_W:0]       q_count;

  assign busy = (32'(q_count) + 32'(inflight)) >= scs_pkg::QDEPTH;

  scs_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
    .clk, .rst,
    .in_valid (start && !busy),
    .op, .in_degrees, .angle,
    .out_valid(f_valid),
    .out_item (f_item),
    .inflight
  );

  scs_queue u_queue (
    .clk, .rst,
    .push     (f_valid),
    .push_item(f_item),
    .pop      (q_pop),
    .pop_item (q_item),
    .count    (q_count)
  );

  scs_back #(.TERMS(TERMS)) u_back (
    .clk, .rst,
    .in_valid(q_pop),
    .in_item (q_item),
    .strobe,
    .value
  );

endmodule

[hw/rtl/scs_front.sv]
// front end: angle accept, turns multiply, half-turn reduction, scale to radians
// uses scs_pkg
module scs_front #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                op,
  input  logic                in_degrees,
  input  logic signed [31:0]  angle,
  output logic                out_valid,
  output scs_pkg::item_t      out_item,
  output logic [2:0]          inflight
);

  localparam int T_R  = ANGLE_FRAC_BITS + scs_pkg::RAD_SHIFT;
  localparam int T_D  = ANGLE_FRAC_BITS + scs_pkg::DEG_SHIFT;
  localparam int SH_R = T_R - 32;
  localparam int SH_D = T_D - 32;

  logic        va, vb, vc, vd;
  logic        a_op, a_deg, a_sneg;
  logic [63:0] a_t;
  logic        b_op, b_deg, b_sneg, b_kodd;
  logic [63:0] b_t, b_kt;
  logic        c_op, c_neg;
  logic [31:0] c_fq;
  scs_pkg::item_t d_item;

  logic [31:0] m;
  logic [63:0] t_prod, sum_r, sum_d;
  logic        fneg;
  logic [63:0] fm, fq_r, fq_d;
  logic [63:0] rm_prod;

  always_comb begin
    m      = angle[31] ? 32'(-angle) : 32'(angle);
    t_prod = {32'b0, m} * {32'b0, (in_degrees ? scs_pkg::INV_180_Q38 : scs_pkg::INV_PI_Q33)};
    sum_r  = a_t + ((64'd1 << (T_R - 1)) - 64'd1);
    sum_d  = a_t + ((64'd1 << (T_D - 1)) - 64'd1);
    fneg   = b_t < b_kt;
    fm     = fneg ? (b_kt - b_t) : (b_t - b_kt);
    fq_r   = (fm + (64'd1 << (SH_R - 1))) >> SH_R;
    fq_d   = (fm + (64'd1 << (SH_D - 1))) >> SH_D;
    rm_prod = (({32'b0, c_fq} * {32'b0, scs_pkg::PI_Q30}) + (64'd1 << 31)) >> 32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
    a_op   <= op;
    a_deg  <= in_degrees;
    a_sneg <= angle[31];
    a_t    <= t_prod;

    b_op   <= a_op;
    b_deg  <= a_deg;
    b_sneg <= a_sneg;
    b_t    <= a_t;
    if (a_deg) begin
      b_kt   <= sum_d & ~((64'd1 << T_D) - 64'd1);
      b_kodd <= sum_d[T_D];
    end else begin
      b_kt   <= sum_r & ~((64'd1 << T_R) - 64'd1);
      b_kodd <= sum_r[T_R];
    end

    c_op  <= b_op;
    c_neg <= b_op ? b_kodd : (b_sneg ^ fneg ^ b_kodd);
    c_fq  <= b_deg ? fq_d[31:0] : fq_r[31:0];

    d_item.op  <= c_op;
    d_item.neg <= c_neg;
    d_item.rm  <= rm_prod[30:0];
  end

  assign out_valid = vd;
  assign out_item  = d_item;
  assign inflight  = 3'(va) + 3'(vb) + 3'(vc) + 3'(vd);

endmodule

[hw/rtl/scs_queue.sv]
// short fifo between the front end and the series back end
// uses scs_pkg and sine_cosine_series_assert.svh
`include "sine_cosine_series_assert.svh"
module scs_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  scs_pkg::item_t              push_item,
  output logic                        pop,
  output scs_pkg::item_t              pop_item,
  output logic [scs_pkg::QPTR_W:0]    count
);

  scs_pkg::item_t             mem [scs_pkg::QDEPTH];
  logic [scs_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [scs_pkg::QPTR_W:0]   count_next;

  assign pop        = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign count_next = count + (scs_pkg::QPTR_W+1)'(push) - (scs_pkg::QPTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `SCS_ASSERT_NOW(a_no_overflow, push, (32'(count) < scs_pkg::QDEPTH) || pop)
  `SCS_ASSERT_NOW(a_count_bound, 1'b1, 32'(count) <= scs_pkg::QDEPTH)
  `SCS_ASSERT_NEXT(a_count_step, 1'b1, count == $past(count_next))

endmodule

[hw/rtl/scs_back.sv]
// back end: horner series pipeline, sign, saturation and result register
// uses scs_pkg
module scs_back #(
  parameter int TERMS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  scs_pkg::item_t      in_item,
  output logic                strobe,
  output logic signed [31:0]  value
);

  localparam int L = TERMS - 1;

  logic                v   [TERMS];
  logic                ops [TERMS];
  logic                ng  [TERMS];
  logic [30:0]         rm  [TERMS];
  logic [31:0]         r2  [TERMS];
  logic signed [33:0]  acc [TERMS];

  logic [61:0]        sq;
  logic signed [33:0] fin, fin_s;

  assign sq = 62'(({31'b0, in_item.rm} * {31'b0, in_item.rm}) + (62'd1 << 29));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < TERMS; j++) begin
        v[j] <= 1'b0;
      end
    end else begin
      v[0] <= in_valid;
      for (int j = 1; j < TERMS; j++) begin
        v[j] <= v[j-1];
      end
    end
    ops[0] <= in_item.op;
    ng[0]  <= in_item.neg;
    rm[0]  <= in_item.rm;
    r2[0]  <= sq[61:30];
    acc[0] <= scs_pkg::coef(5'(2 * L) + 5'(!in_item.op));
    for (int j = 1; j < TERMS; j++) begin
      ops[j] <= ops[j-1];
      ng[j]  <= ng[j-1];
      rm[j]  <= rm[j-1];
      r2[j]  <= r2[j-1];
      acc[j] <= scs_pkg::coef(5'(2 * (L - j)) + 5'(!ops[j-1]))
                - scs_pkg::mul_q30(acc[j-1], r2[j-1]);
    end
  end

  always_comb begin
    fin   = ops[L] ? acc[L] : scs_pkg::mul_q30(acc[L], {1'b0, rm[L]});
    fin_s = ng[L] ? -fin : fin;
    if (fin_s > scs_pkg::ONE_Q30) begin
      fin_s = scs_pkg::ONE_Q30;
    end else if (fin_s < scs_pkg::NEG_ONE_Q30) begin
      fin_s = scs_pkg::NEG_ONE_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= v[L];
    end
    value <= fin_s[31:0];
  end

endmodule

[test/tb.sv]
// testbench for sine_cosine_series: directed table then random angles
// predicts values the table does not give with a local fixed-point series model; needs scs_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TERMS = 8;
  localparam int AFB = 16;
  localparam int LAT = 6 + TERMS;
  localparam int WATCHDOG = 5000;
  localparam int N_RANDOM = 1900;
  localparam logic OP_SIN = 1'b0;
  localparam logic OP_COS = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = 1'b0;
  logic in_degrees = 1'b0;
  logic signed [31:0] angle = '0;
  logic busy, strobe;
  logic signed [31:0] value;

  logic signed [31:0] expected_values[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle = 0;

  typedef struct {
    logic o;
    logic d;
    logic [31:0] a;
    bit known;
    logic signed [31:0] v;
  } row_t;

  sine_cosine_series #(.TERMS(TERMS), .ANGLE_FRAC_BITS(AFB)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .in_degrees(in_degrees), .angle(angle), .strobe(strobe), .value(value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint series_coef(int n);
    longint tbl[13] = '{1073741824, 1073741824, 536870912, 178956971, 44739243,
      8947849, 1491308, 213044, 26631, 2959, 296, 27, 2};
    return n < 13 ? tbl[n] : 0;
  endfunction

  function automatic longint round_mul(longint a, longint unsigned b);
    longint unsigned mag, p;
    mag = a < 0 ? -a : a;
    p = (mag * b + (64'd1 << 29)) >> 30;
    return a < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [31:0] trig_value(logic o, logic d, logic [31:0] a);
    bit sneg, fneg, neg;
    longint unsigned m, t, half, k, kt, fm, fq, rm, r2;
    int tb_shift, sh, b;
    longint acc, v;
    sneg = a[31];
    m = sneg ? (64'h1_0000_0000 - a) : a;
    tb_shift = d ? AFB + scs_pkg::DEG_SHIFT : AFB + scs_pkg::RAD_SHIFT;
    t = m * (d ? 64'(scs_pkg::INV_180_Q38) : 64'(scs_pkg::INV_PI_Q33));
    half = 64'd1 << (tb_shift - 1);
    k = (t + half - 1) >> tb_shift;
    kt = k << tb_shift;
    fneg = t < kt;
    fm = fneg ? kt - t : t - kt;
    sh = tb_shift - 32;
    fq = (fm + (64'd1 << (sh - 1))) >> sh;
    rm = (fq * 64'(scs_pkg::PI_Q30) + (64'd1 << 31)) >> 32;
    r2 = (rm * rm + (64'd1 << 29)) >> 30;
    b = o ? 0 : 1;
    acc = series_coef(2 * (TERMS - 1) + b);
    for (int i = TERMS - 2; i >= 0; i--) acc = series_coef(2 * i + b) - round_mul(acc, r2);
    if (o == OP_SIN) begin
      v = round_mul(acc, rm);
      neg = sneg ^ fneg ^ k[0];
    end else begin
      v = acc;
      neg = k[0];
    end
    if (neg) v = -v;
    if (v > 1073741824) v = 1073741824;
    if (v < -1073741824) v = -1073741824;
    return 32'(v);
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // one transfer; idle probability in percent
  task automatic send(logic o, logic d, logic [31:0] a, bit known,
                      logic signed [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    in_degrees <= d;
    angle <= a;
    do @(posedge clk); while (busy);
    expected_values.push_back(known ? v : trig_value(o, d, a));
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_values.size() == 0) report_mismatch("unexpected", value, 'x);
      else begin
        if (value !== expected_values[0]) report_mismatch("value", value, expected_values[0]);
        void'(expected_values.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int phase_idle[4] = '{0, 75, 0, 28};
    logic [31:0] a;
    int r;
    rows = '{
      '{OP_SIN, 1'b0, 32'h0, 1, 32'sd0},
      '{OP_COS, 1'b0, 32'h0, 1, 32'sd1073741824},
      '{OP_SIN, 1'b1, 32'h0, 1, 32'sd0},
      '{OP_COS, 1'b1, 32'h0, 1, 32'sd1073741824},
      '{OP_SIN, 1'b1, 32'd90 << 16, 0, 0},
      '{OP_COS, 1'b1, 32'd180 << 16, 0, 0},
      '{OP_SIN, 1'b1, -(32'd90 << 16), 0, 0},
      '{OP_SIN, 1'b1, 32'd270 << 16, 0, 0},
      '{OP_COS, 1'b1, 32'd360 << 16, 0, 0},
      '{OP_SIN, 1'b0, 32'h7fffffff, 0, 0},
      '{OP_COS, 1'b0, 32'h7fffffff, 0, 0},
      '{OP_SIN, 1'b0, 32'h80000000, 0, 0},
      '{OP_COS, 1'b0, 32'h80000000, 0, 0},
      '{OP_SIN, 1'b1, 32'h7fffffff, 0, 0},
      '{OP_COS, 1'b1, 32'h80000000, 0, 0},
      '{OP_SIN, 1'b0, 32'h0001921f, 0, 0},
      '{OP_COS, 1'b0, 32'hfffe6de1, 0, 0},
      '{OP_SIN, 1'b0, 32'h00000001, 0, 0},
      '{OP_COS, 1'b0, 32'hffffffff, 0, 0},
      '{OP_SIN, 1'b1, 32'd45 << 16, 0, 0},
      '{OP_COS, 1'b1, 32'hffffffff, 0, 0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].o, rows[i].d, rows[i].a, rows[i].known, rows[i].v);
    for (int n = 0; n < N_RANDOM; n++) begin
      send_idle = phase_idle[n * 4 / N_RANDOM];
      r = $urandom_range(3);
      case (r)
        0: a = $urandom;
        1: a = 32'($signed($urandom_range(720)) - 360) << 16 | $urandom_range(1);
        2: a = 32'($signed($urandom_range(1600000)) - 800000);
        default: a = ($urandom_range(1) ? 32'h7fff0000 : 32'h8000ffff) ^ $urandom_range(65535);
      endcase
      send(1'($urandom_range(1)), 1'($urandom_range(1)), a, 0, 0);
    end
    start <= 1'b0;
    for (int w = 0; w < 100 * LAT && expected_values.size() != 0; w++) @(posedge clk);
    repeat (LAT) @(posedge clk);
    if (errors == 0 && expected_values.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[sine_cosine_series.f]
+incdir+hw/rtl
hw/rtl/scs_pkg.sv
hw/rtl/scs_front.sv
hw/rtl/scs_queue.sv
hw/rtl/scs_back.sv
hw/rtl/sine_cosine_series.sv
test/tb.sv
